>>> hw/rtl/wlc_pkg.sv
package wlc_pkg;

  localparam int N_ENTRIES = 64;
  localparam int IDX_W     = $clog2(N_ENTRIES);
  localparam int OCC_W     = $clog2(N_ENTRIES + 1);
  localparam int ADDR_W    = 36;
  localparam int DATA_W    = 64;
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 32;
  localparam int ADDR_LAT  = 4;
  localparam int CNT_W     = $clog2(ADDR_LAT + 1);

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_EBYTES = 2'd2,
    REG_BASE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_HIT   = 3'd0,
    KIND_FETCH = 3'd1,
    KIND_WB    = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_READ, OP_WRITE, OP_FILL, OP_FLUSH, OP_ERR
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MATCH, ST_SELECT, ST_DECIDE, ST_HITOUT, ST_VTAG, ST_AWAIT,
    ST_UPDATE, ST_FL_FIND, ST_FL_SEL, ST_FL_RD, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [DATA_W-1:0]   value;
  } job_t;

  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [3:0]         eff;
    logic [31:0]        base;
  } cfg_t;

  function automatic logic [3:0] eff_bytes(input logic [3:0] b);
    logic [3:0] r;
    if (b == 4'd0) r = 4'd1;
    else if (b > 4'd8) r = 4'd8;
    else r = b;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] value_mask(input logic [3:0] eff);
    logic [DATA_W-1:0] m;
    for (int j = 0; j < 8; j++) begin
      m[8*j +: 8] = (4'(j) < eff) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [IDX_W-1:0] first_set(input logic [N_ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = N_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/wlc_if.sv
interface wlc_req_if import wlc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [DATA_W-1:0]  write_data;
  modport source (output valid, cmd, col, row, write_data, input ready);
  modport sink (input valid, cmd, col, row, write_data, output ready);
endinterface

interface wlc_rsp_if import wlc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] read_data;
  logic              last;
  modport source (output valid, kind, address, read_data, last, input ready);
  modport sink (input valid, kind, address, read_data, last, output ready);
endinterface

>>> hw/rtl/wlc_ram.sv
module wlc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/wlc_front.sv
module wlc_front import wlc_pkg::*; (
  wlc_req_if.sink req,
  input  cfg_t    cfg,
  input  logic    q_full,
  output logic    push,
  output job_t    job
);
  logic oob;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;
  assign oob       = (req.col >= cfg.width) || (req.row >= cfg.height);

  always_comb begin
    job.col   = req.col;
    job.row   = req.row;
    job.value = req.write_data & value_mask(cfg.eff);
    case (req.cmd)
      CMD_FLUSH: job.op = OP_FLUSH;
      CMD_READ:  job.op = oob ? OP_ERR : OP_READ;
      CMD_WRITE: job.op = oob ? OP_ERR : OP_WRITE;
      CMD_FILL:  job.op = oob ? OP_ERR : OP_FILL;
      default:   job.op = OP_ERR;
    endcase
  end
endmodule

>>> hw/rtl/wlc_queue.sv
module wlc_queue import wlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);
  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end
endmodule

>>> hw/rtl/wlc_addr.sv
module wlc_addr import wlc_pkg::*; (
  input  logic               clk,
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  output logic [ADDR_W-1:0]  addr
);
  logic [31:0]        prod;
  logic [COORD_W-1:0] col_d;
  logic [32:0]        lin;
  logic [ADDR_W-1:0]  offs;

  always_ff @(posedge clk) begin
    prod  <= row * cfg.width;
    col_d <= col;
    lin   <= {1'b0, prod} + 33'(col_d);
    offs  <= ADDR_W'(lin) * ADDR_W'(cfg.eff);
    addr  <= offs + ADDR_W'(cfg.base);
  end
endmodule

>>> hw/rtl/wlc_back.sv
module wlc_back import wlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_avail,
  input  job_t q_head,
  output logic q_pop,
  wlc_rsp_if.source rsp
);
  state_t state, state_next, ret_state;
  job_t   job;

  logic [N_ENTRIES-1:0] valid, dirty;
  logic [COORD_W-1:0]   tag_col [N_ENTRIES];
  logic [COORD_W-1:0]   tag_row [N_ENTRIES];
  logic [IDX_W-1:0]     rank [N_ENTRIES];
  logic [OCC_W-1:0]     occ;

  logic [N_ENTRIES-1:0] match_vec, victim_vec, free_vec, sel_vec;
  logic [N_ENTRIES-1:0] match_now, victim_now, sel_now;
  logic [IDX_W-1:0]     hit_rank, hit_rank_now;
  logic [IDX_W-1:0]     idx;
  logic                 hit, full, vdirty;
  logic [OCC_W-1:0]     fl_rank, old_rank;
  logic                 fl_last, wb_any;
  logic [CNT_W-1:0]     cnt;
  logic [COORD_W-1:0]   a_col, a_row;
  logic [ADDR_W-1:0]    a_addr;
  logic [DATA_W-1:0]    wb_val;

  logic [2:0]           res_kind;
  logic [ADDR_W-1:0]    res_addr;
  logic [DATA_W-1:0]    res_data;
  logic                 res_last;

  logic                 o_valid, o_last, load;
  logic [2:0]           o_kind;
  logic [ADDR_W-1:0]    o_addr;
  logic [DATA_W-1:0]    o_data;

  logic                 ram_we;
  logic [DATA_W-1:0]    val_rd;
  logic [2*COORD_W-1:0] tag_rd;

  wlc_ram #(.WIDTH(DATA_W), .DEPTH(N_ENTRIES)) u_val_ram (
    .clk(clk), .we(ram_we), .waddr(idx), .wdata(job.value),
    .raddr(idx), .rdata(val_rd)
  );

  wlc_ram #(.WIDTH(2*COORD_W), .DEPTH(N_ENTRIES)) u_tag_ram (
    .clk(clk), .we(ram_we), .waddr(idx), .wdata({job.col, job.row}),
    .raddr(idx), .rdata(tag_rd)
  );

  wlc_addr u_addr (.clk(clk), .cfg(cfg), .col(a_col), .row(a_row), .addr(a_addr));

  // Per-slot compares; each slot is only looked at in its own place.
  always_comb begin
    hit_rank_now = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      match_now[i]  = valid[i] && tag_col[i] == job.col && tag_row[i] == job.row;
      victim_now[i] = valid[i] && rank[i] == IDX_W'(N_ENTRIES - 1);
      sel_now[i]    = valid[i] && OCC_W'(rank[i]) == fl_rank;
      if (match_now[i]) hit_rank_now = hit_rank_now | rank[i];
    end
  end

  assign old_rank = hit ? OCC_W'(hit_rank) : OCC_W'(N_ENTRIES);
  assign load     = !o_valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_avail) begin
          case (q_head.op)
            OP_ERR:   state_next = ST_EMIT;
            OP_FLUSH: state_next = ST_FL_FIND;
            default:  state_next = ST_MATCH;
          endcase
        end
      end
      ST_MATCH:  state_next = ST_SELECT;
      ST_SELECT: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (job.op == OP_READ) state_next = hit ? ST_HITOUT : ST_AWAIT;
        else if (!hit && full && vdirty) state_next = ST_VTAG;
        else state_next = ST_UPDATE;
      end
      ST_HITOUT: state_next = ST_EMIT;
      ST_VTAG:   state_next = ST_AWAIT;
      ST_AWAIT:  if (cnt == '0) state_next = ST_EMIT;
      ST_UPDATE: state_next = ST_EMIT;
      ST_FL_FIND: begin
        if (fl_rank >= occ) state_next = wb_any ? ST_IDLE : ST_EMIT;
        else state_next = ST_FL_SEL;
      end
      ST_FL_SEL: state_next = (|(sel_vec & dirty)) ? ST_FL_RD : ST_FL_FIND;
      ST_FL_RD:  state_next = ST_VTAG;
      ST_EMIT:   if (load) state_next = ret_state;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == ST_IDLE) && q_avail;
    ram_we = (state == ST_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      dirty   <= '0;
      occ     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && load) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
      if (state == ST_UPDATE) begin
        valid[idx] <= 1'b1;
        dirty[idx] <= (job.op == OP_WRITE);
        if (!hit && !full) occ <= occ + 1'b1;
      end
      if (state == ST_FL_SEL) dirty <= dirty & ~sel_vec;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job      <= q_head;
        fl_rank  <= '0;
        wb_any   <= 1'b0;
        res_kind <= KIND_ERR;
        res_addr <= '0;
        res_data <= '0;
        res_last <= 1'b1;
        ret_state <= ST_IDLE;
      end
      ST_MATCH: begin
        match_vec  <= match_now;
        victim_vec <= victim_now;
        free_vec   <= ~valid;
        hit_rank   <= hit_rank_now;
        full       <= (occ == OCC_W'(N_ENTRIES));
      end
      ST_SELECT: begin
        hit    <= |match_vec;
        vdirty <= |(victim_vec & dirty);
        if (|match_vec) idx <= first_set(match_vec);
        else if (full) idx <= first_set(victim_vec);
        else idx <= first_set(free_vec);
      end
      ST_DECIDE: begin
        a_col <= job.col;
        a_row <= job.row;
        cnt   <= CNT_W'(ADDR_LAT);
        wb_val <= '0;
      end
      ST_HITOUT: begin
        res_kind  <= KIND_HIT;
        res_addr  <= '0;
        res_data  <= val_rd;
        res_last  <= 1'b1;
        ret_state <= ST_IDLE;
      end
      ST_VTAG: begin
        a_col  <= tag_rd[2*COORD_W-1:COORD_W];
        a_row  <= tag_rd[COORD_W-1:0];
        wb_val <= val_rd;
        cnt    <= CNT_W'(ADDR_LAT);
      end
      ST_AWAIT: begin
        cnt      <= cnt - 1'b1;
        res_addr <= a_addr;
        res_data <= wb_val;
        if (job.op == OP_READ) begin
          res_kind  <= KIND_FETCH;
          res_last  <= 1'b1;
          ret_state <= ST_IDLE;
        end else if (job.op == OP_FLUSH) begin
          res_kind  <= KIND_WB;
          res_last  <= fl_last;
          ret_state <= ST_FL_FIND;
        end else begin
          res_kind  <= KIND_WB;
          res_last  <= 1'b0;
          ret_state <= ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (IDX_W'(i) == idx) rank[i] <= '0;
          else if (valid[i] && OCC_W'(rank[i]) < old_rank) rank[i] <= rank[i] + 1'b1;
        end
        tag_col[idx] <= job.col;
        tag_row[idx] <= job.row;
        res_kind  <= KIND_DONE;
        res_addr  <= '0;
        res_data  <= '0;
        res_last  <= 1'b1;
        ret_state <= ST_IDLE;
      end
      ST_FL_FIND: begin
        sel_vec   <= sel_now;
        res_kind  <= KIND_DONE;
        res_addr  <= '0;
        res_data  <= '0;
        res_last  <= 1'b1;
        ret_state <= ST_IDLE;
      end
      ST_FL_SEL: begin
        idx     <= first_set(sel_vec);
        fl_rank <= fl_rank + 1'b1;
        // The write-back is the final item once no other dirty entry remains.
        fl_last <= ((dirty & ~sel_vec) == '0);
        if (|(sel_vec & dirty)) wb_any <= 1'b1;
      end
      default: begin
      end
    endcase
    if (state == ST_EMIT && load) begin
      o_kind <= res_kind;
      o_addr <= res_addr;
      o_data <= res_data;
      o_last <= res_last;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.kind      = o_kind;
  assign rsp.address   = o_addr;
  assign rsp.read_data = o_data;
  assign rsp.last      = o_last;
endmodule

>>> hw/rtl/write_back_lru_element_cache.sv
// A read hit returns the stored value; a read miss waits on the address pipeline.
// A write or fill first writes back a dirty victim when it must evict one.
// A flush walks the occupied ranks and writes back each dirty entry it finds.
// The back end handles one item at a time; a two-item queue lets the input run ahead.
// Synchronous active-high reset empties the cache, clears dirty marks and restores
// the registers to width 1, height 1, one byte per element and base address 16.
module write_back_lru_element_cache import wlc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  wlc_req_if.sink          req,
  wlc_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  cfg_t cfg;
  logic [COORD_W-1:0] cfg_width;
  logic [COORD_W-1:0] cfg_height;
  logic [31:0] cfg_base;
  logic [3:0] ebytes;
  logic q_full, push, q_pop, q_avail;
  job_t push_job, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= COORD_W'(1);
      cfg_height <= COORD_W'(1);
      ebytes     <= 4'd1;
      cfg_base   <= 32'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_width  <= cfg_data[COORD_W-1:0];
        REG_HEIGHT: cfg_height <= cfg_data[COORD_W-1:0];
        REG_EBYTES: ebytes     <= cfg_data[3:0];
        REG_BASE:   cfg_base   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{width: cfg_width, height: cfg_height, eff: eff_bytes(ebytes),
                 base: cfg_base};

  wlc_front u_front (.req(req), .cfg(cfg), .q_full(q_full), .push(push), .job(push_job));

  wlc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .full(q_full),
    .pop(q_pop), .avail(q_avail), .head(q_head)
  );

  wlc_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_avail(q_avail), .q_head(q_head),
    .q_pop(q_pop), .rsp(rsp)
  );
endmodule

>>> hw/rtl/wlc_checker.sv
module wlc_checker import wlc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic [2:0]        kind,
  input logic [ADDR_W-1:0] address,
  input logic [DATA_W-1:0] read_data,
  input logic              last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result dropped while stalled");

  a_single: assert property (@(posedge clk) disable iff (rst)
    valid && (kind == KIND_HIT || kind == KIND_FETCH || kind == KIND_DONE ||
              kind == KIND_ERR) |-> last)
    else $error("single-result item without last");

  a_noaddr: assert property (@(posedge clk) disable iff (rst)
    valid && (kind == KIND_HIT || kind == KIND_DONE || kind == KIND_ERR) |-> address == '0)
    else $error("address set on a result that carries none");

  a_nodata: assert property (@(posedge clk) disable iff (rst)
    valid && (kind == KIND_FETCH || kind == KIND_DONE || kind == KIND_ERR) |-> read_data == '0)
    else $error("data set on a result that carries none");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !valid)
    else $error("result shown straight after reset");
endmodule

bind write_back_lru_element_cache wlc_checker u_checker (
  .clk(clk), .rst(rst), .valid(rsp.valid), .ready(rsp.ready), .kind(rsp.kind),
  .address(rsp.address), .read_data(rsp.read_data), .last(rsp.last)
);

>>> dv/write_back_lru_element_cache_tb.sv
module write_back_lru_element_cache_tb;
  import wlc_pkg::*;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] read_data;
    logic              last;
  } cache_result_t;

  class cache_scoreboard;
    logic [15:0] width = 16'd1;
    logic [15:0] height = 16'd1;
    logic [3:0]  ebytes = 4'd1;
    logic [31:0] base = 32'd16;

    bit                slot_valid[N_ENTRIES];
    logic [15:0]       slot_col[N_ENTRIES];
    logic [15:0]       slot_row[N_ENTRIES];
    logic [DATA_W-1:0] slot_value[N_ENTRIES];
    bit                slot_dirty[N_ENTRIES];
    int                slot_rank[N_ENTRIES];
    int                occupancy;

    cache_result_t expected_results[$];
    int errors;
    int items;
    int results;
    int kind_seen[5];

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_WIDTH:  width = v[15:0];
        REG_HEIGHT: height = v[15:0];
        REG_EBYTES: ebytes = v[3:0];
        REG_BASE:   base = v;
        default: ;
      endcase
    endfunction

    function int bytes_used();
      if (ebytes == 0) return 1;
      if (ebytes > 8) return 8;
      return ebytes;
    endfunction

    function logic [ADDR_W-1:0] element_address(logic [15:0] c, logic [15:0] r);
      logic [63:0] a;
      a = 64'(base) + (64'(r) * 64'(width) + 64'(c)) * 64'(bytes_used());
      return a[ADDR_W-1:0];
    endfunction

    function void push(kind_t k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d, bit l);
      cache_result_t e;
      e.kind = k;
      e.address = a;
      e.read_data = d;
      e.last = l;
      expected_results.push_back(e);
    endfunction

    function int lookup(logic [15:0] c, logic [15:0] r);
      for (int i = 0; i < N_ENTRIES; i++)
        if (slot_valid[i] && slot_col[i] == c && slot_row[i] == r) return i;
      return -1;
    endfunction

    // Entries more recent than the old rank of slot s age by one.
    function void make_recent(int s, int old_rank);
      for (int i = 0; i < N_ENTRIES; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[s] = 0;
    endfunction

    function void store(logic [15:0] c, logic [15:0] r, logic [DATA_W-1:0] v, bit dirty);
      int s;
      logic [DATA_W-1:0] m;
      s = lookup(c, r);
      if (s >= 0) begin
        make_recent(s, slot_rank[s]);
      end else if (occupancy >= N_ENTRIES) begin
        s = 0;
        for (int i = 0; i < N_ENTRIES; i++)
          if (slot_valid[i] && slot_rank[i] == N_ENTRIES - 1) begin
            s = i;
            break;
          end
        if (slot_dirty[s])
          push(KIND_WB, element_address(slot_col[s], slot_row[s]), slot_value[s], 0);
        make_recent(s, N_ENTRIES);
      end else begin
        s = 0;
        for (int i = 0; i < N_ENTRIES; i++)
          if (!slot_valid[i]) begin
            s = i;
            break;
          end
        slot_valid[s] = 1;
        occupancy++;
        make_recent(s, N_ENTRIES);
      end
      m = '0;
      for (int j = 0; j < bytes_used(); j++) m[8*j +: 8] = 8'hFF;
      slot_col[s] = c;
      slot_row[s] = r;
      slot_value[s] = v & m;
      slot_dirty[s] = dirty;
      push(KIND_DONE, '0, '0, 1);
    endfunction

    function void note_item(cmd_t cmd, logic [15:0] c, logic [15:0] r, logic [DATA_W-1:0] v);
      int s;
      int n;
      items++;
      if (cmd == CMD_FLUSH) begin
        n = 0;
        for (int rank = 0; rank < occupancy; rank++)
          for (int i = 0; i < N_ENTRIES; i++)
            if (slot_valid[i] && slot_rank[i] == rank) begin
              if (slot_dirty[i]) begin
                push(KIND_WB, element_address(slot_col[i], slot_row[i]), slot_value[i], 0);
                slot_dirty[i] = 0;
                n++;
              end
              break;
            end
        if (n == 0) push(KIND_DONE, '0, '0, 1);
        else expected_results[$].last = 1;
      end else if (c >= width || r >= height) begin
        push(KIND_ERR, '0, '0, 1);
      end else if (cmd == CMD_READ) begin
        s = lookup(c, r);
        if (s >= 0) push(KIND_HIT, '0, slot_value[s], 1);
        else push(KIND_FETCH, element_address(c, r), '0, 1);
      end else begin
        store(c, r, v, cmd == CMD_WRITE);
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t want;
      results++;
      if (expected_results.size() == 0) begin
        $error("result kind %0d arrived with nothing outstanding", got.kind);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.kind < 5) kind_seen[got.kind]++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.address !== want.address) begin
        $error("address: expected %h actual %h", want.address, got.address);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h actual %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit calm;
  int stall_left;

  wlc_req_if req ();
  wlc_rsp_if rsp ();

  cache_scoreboard sb = new;

  write_back_lru_element_cache u_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      sb.note_item(cmd_t'(req.cmd), req.col, req.row, req.write_data);
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.kind, rsp.address, rsp.read_data, rsp.last});
  end

  // Result-side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic send(cmd_t cmd, logic [15:0] c, logic [15:0] r, logic [DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.col <= c;
    req.row <= r;
    req.write_data <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
  endtask

  task automatic end_config();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n, int span);
    int p;
    cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      cmd = p < 35 ? CMD_READ : p < 65 ? CMD_WRITE : p < 92 ? CMD_FILL : CMD_FLUSH;
      calm = (i % 40) >= 30;
      if (span == 0)
        send(cmd, 16'($urandom), 16'($urandom), {$urandom, $urandom});
      else
        send(cmd, 16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
             {$urandom, $urandom});
    end
    calm = 0;
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    stall_left = 0;
    req.valid = 0;
    req.cmd = '0;
    req.col = '0;
    req.row = '0;
    req.write_data = '0;
    rsp.ready = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Reset configuration: a single element at address 16, one byte wide.
    send(CMD_READ, 0, 0, 0);
    send(CMD_READ, 1, 0, 0);
    send(CMD_WRITE, 0, 16'hFFFF, '1);
    send(CMD_WRITE, 0, 0, '1);
    send(CMD_READ, 0, 0, 0);
    send(CMD_FILL, 0, 0, 64'h5A);
    send(CMD_FLUSH, 0, 0, 0);
    send(CMD_WRITE, 0, 0, 64'hA5);
    send(CMD_FLUSH, 16'hFFFF, 16'hFFFF, '1);
    send(CMD_FLUSH, 0, 0, 0);
    send(CMD_READ, 16'hFFFF, 16'hFFFF, 0);
    drain();

    // Largest matrix, widest elements, top base address.
    write_reg(REG_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT, 32'h0000_FFFF);
    write_reg(REG_EBYTES, 32'd8);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    end_config();
    send(CMD_WRITE, 16'hFFFE, 16'hFFFE, '1);
    send(CMD_READ, 16'hFFFE, 16'hFFFE, 0);
    send(CMD_READ, 16'hFFFF, 0, 0);
    send(CMD_READ, 16'hFFFE, 16'hFFFD, 0);
    send(CMD_FLUSH, 0, 0, 0);
    random_items(20, 0);
    drain();

    // Zero width makes every coordinate out of range; zero bytes act as one.
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_EBYTES, 32'd0);
    write_reg(REG_BASE, 32'd0);
    end_config();
    send(CMD_WRITE, 0, 0, 64'h1234);
    send(CMD_READ, 0, 0, 0);
    drain();

    // A 10 by 10 matrix holds more elements than the cache, so victims occur.
    write_reg(REG_WIDTH, 32'd10);
    write_reg(REG_HEIGHT, 32'd10);
    write_reg(REG_BASE, $urandom);
    end_config();
    random_items(80, 11);
    drain();

    // Oversized element width is clamped to eight bytes.
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd40);
    write_reg(REG_EBYTES, 32'd13);
    write_reg(REG_BASE, $urandom);
    end_config();
    for (int i = 0; i < 70; i++) begin
      if (i % 25 < 3)
        send(CMD_FLUSH, 16'($urandom), 16'($urandom), {$urandom, $urandom});
      else
        send(cmd_t'($urandom_range(0, 2)), 16'($urandom_range(0, 3)),
             16'($urandom_range(0, 41)), {$urandom, $urandom});
    end
    drain();
    write_reg(REG_EBYTES, 32'd15);
    end_config();

    $display("Ran %0d items over five register settings, %0d results checked.",
             sb.items, sb.results);
    $display("Hits %0d, fetches %0d, write-backs %0d, done %0d, range errors %0d.",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4]);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("write_back_lru_element_cache verification clean");
    end else begin
      $display("write_back_lru_element_cache verification failed");
    end
    $finish;
  end

  initial begin
    #(20 * 4000000);
    $display("write_back_lru_element_cache verification failed");
    $finish;
  end

endmodule
